// File: rtl/frame_flip_transpose_macros.svh
// Assertion macros for the frame reorientation block.
// Used by the checker module; expects clk and rst_n in scope.
`ifndef FRAME_FLIP_TRANSPOSE_MACROS_SVH
`define FRAME_FLIP_TRANSPOSE_MACROS_SVH

// same-cycle implication
`define FFXP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFXP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// delayed implication: the consequent is checked after the next-cycle check
`define FFXP_ASSERT_NXT2(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

// File: rtl/ffxp_pkg.sv
// Shared constants, types and codes of the frame reorientation block.
// No dependencies.
package ffxp_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int BANK_WORDS = MAX_WIDTH * MAX_HEIGHT;
    localparam int BANK_AW    = $clog2(BANK_WORDS);
    localparam int RAM_AW     = BANK_AW + 1;
    localparam int RAM_DEPTH  = 2 * BANK_WORDS;
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CNT_W      = $clog2(MAX_DIM);

    localparam int PIX_W      = 32;
    localparam int DIM_W      = 9;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_VFLIP     = 2'd0,
        MODE_HFLIP     = 2'd1,
        MODE_TRANSPOSE = 2'd2
    } orient_t;

    typedef logic [DIM_W-1:0] dim_t;

    // memory request issued with each accepted pixel
    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic              re;
        logic [RAM_AW-1:0] raddr;
    } ram_req_t;

    // per-request tags that follow the read data
    typedef struct packed {
        logic prior_ok;
        logic frame_end;
    } meta_t;

endpackage

// File: rtl/ffxp_if.sv
// Valid/ready channel interfaces for pixel input and reoriented output.
// Depends on ffxp_pkg.
interface ffxp_in_if;
    logic                       valid;
    logic                       ready;
    logic [ffxp_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

interface ffxp_out_if;
    logic                       valid;
    logic                       ready;
    logic [ffxp_pkg::PIX_W-1:0] pixel_out;
    logic                       out_valid;
    logic                       frame_end;

    modport source (output valid, output pixel_out, output out_valid, output frame_end,
                    input ready);
    modport sink (input valid, input pixel_out, input out_valid, input frame_end,
                  output ready);
endinterface

// File: rtl/frame_flip_transpose.sv
// Top level of the frame reorientation block: double-buffered frame store.
// Depends on ffxp_pkg, ffxp_if, ffxp_ram, ffxp_ctrl, ffxp_out.
//
//  port       | dir  | payload                           | accepted when
//  -----------+------+-----------------------------------+---------------------
//  in_ch      | sink | pixel_in[31:0]                    | valid && ready
//  out_ch     | src  | pixel_out[31:0], out_valid, frame_end | valid && ready
//  cfg_*      | in   | cfg_index[1:0], cfg_data[8:0]     | cfg_we
//
// One pixel per clock sustained while in_ch.ready stays high; each request does one write
// and one read on the two ports of the frame store.
// Each input request passes through the registered RAM read and the output
// register on its way to the output.
// The store is not cleared at reset; the first frame is flagged out_valid = 0.
// in_ch.ready drops only while both the read stage and the output register
// hold requests and out_ch.ready is low.
module frame_flip_transpose (
    input  logic                             clk,
    input  logic                             rst_n,
    ffxp_in_if.sink                          in_ch,
    ffxp_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [ffxp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffxp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ffxp_pkg::*;

    ram_req_t         ram_req;
    meta_t            meta;
    logic             acc, s_ready;
    logic [PIX_W-1:0] rdata;

    assign in_ch.ready = s_ready;
    assign acc         = in_ch.valid && s_ready;

    ffxp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .acc       (acc),
        .pixel     (in_ch.pixel_in),
        .ram_req   (ram_req),
        .meta      (meta)
    );

    ffxp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (rdata)
    );

    ffxp_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .meta    (meta),
        .rdata   (rdata),
        .s_ready (s_ready),
        .dst     (out_ch)
    );

endmodule

// File: rtl/ffxp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ffxp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/ffxp_ctrl.sv
// Configuration registers, write/read counters and address generation.
// Depends on ffxp_pkg.
module ffxp_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ffxp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffxp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             acc,
    input  logic [ffxp_pkg::PIX_W-1:0]       pixel,
    output ffxp_pkg::ram_req_t               ram_req,
    output ffxp_pkg::meta_t                  meta
);
    import ffxp_pkg::*;

    function automatic dim_t clamp_dim(input logic [CFG_DATA_W-1:0] v, input dim_t maxv);
        dim_t r;
        if (v == '0)
        begin
            r = dim_t'(1);
        end
        else if (DIM_W'(v) > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    orient_t             mode_cfg_reg, cur_mode_reg;
    dim_t                w_cfg_reg, h_cfg_reg, cur_w_reg, cur_h_reg;
    logic                wbank_reg, done_reg, prior_reg;
    logic [BANK_AW-1:0]  wpos_reg, base_reg, addr_reg;
    logic [CNT_W-1:0]    in_col_reg, in_row_reg, out_col_reg;

    logic                wbank_next, done_next, prior_next;
    logic [BANK_AW-1:0]  wpos_next, base_next, addr_next;
    logic [CNT_W-1:0]    in_col_next, in_row_next, out_col_next;

    logic                start, last_in, col_wrap, in_wrap;
    orient_t             eff_mode;
    dim_t                eff_w, eff_h, ncols;
    logic [2*DIM_W-1:0]  prod;
    logic [BANK_AW-1:0]  hm1w, w_ext, start_base, start_addr, cur_base, cur_addr;
    logic [BANK_AW-1:0]  row_base;

    assign start    = (wpos_reg == '0);
    assign eff_w    = start ? w_cfg_reg : cur_w_reg;
    assign eff_h    = start ? h_cfg_reg : cur_h_reg;
    assign eff_mode = start ? mode_cfg_reg : cur_mode_reg;
    assign w_ext    = BANK_AW'(eff_w);
    assign ncols    = (eff_mode == MODE_TRANSPOSE) ? eff_h : eff_w;

    // first row of a vertical flip reads the last input row
    assign prod = (2*DIM_W)'(h_cfg_reg - dim_t'(1)) * (2*DIM_W)'(w_cfg_reg);
    assign hm1w = prod[BANK_AW-1:0];

    always_comb
    begin
        unique case (mode_cfg_reg)
            MODE_HFLIP:
            begin
                start_base = '0;
                start_addr = BANK_AW'(w_cfg_reg - dim_t'(1));
            end
            MODE_TRANSPOSE:
            begin
                start_base = '0;
                start_addr = '0;
            end
            default:
            begin
                start_base = hm1w;
                start_addr = hm1w;
            end
        endcase
    end

    assign cur_base = start ? start_base : base_reg;
    assign cur_addr = start ? start_addr : addr_reg;

    assign in_wrap  = (in_col_reg == CNT_W'(eff_w - dim_t'(1)));
    assign last_in  = in_wrap && (in_row_reg == CNT_W'(eff_h - dim_t'(1)));
    assign col_wrap = (out_col_reg == CNT_W'(ncols - dim_t'(1)));

    always_comb
    begin
        unique case (eff_mode)
            MODE_HFLIP:     row_base = cur_base + w_ext;
            MODE_TRANSPOSE: row_base = cur_base + BANK_AW'(1);
            default:        row_base = cur_base - w_ext;
        endcase
    end

    always_comb
    begin
        wbank_next   = wbank_reg;
        done_next    = done_reg;
        prior_next   = prior_reg;
        wpos_next    = wpos_reg;
        base_next    = base_reg;
        addr_next    = addr_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        if (acc)
        begin
            prior_next = start ? (done_reg && w_cfg_reg == cur_w_reg && h_cfg_reg == cur_h_reg)
                               : prior_reg;
            if (last_in)
            begin
                wpos_next    = '0;
                wbank_next   = ~wbank_reg;
                done_next    = 1'b1;
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
            end
            else
            begin
                wpos_next   = wpos_reg + BANK_AW'(1);
                in_col_next = in_wrap ? '0 : in_col_reg + CNT_W'(1);
                in_row_next = in_wrap ? in_row_reg + CNT_W'(1) : in_row_reg;
                if (col_wrap)
                begin
                    out_col_next = '0;
                    base_next    = row_base;
                    addr_next    = (eff_mode == MODE_HFLIP) ? row_base + w_ext - BANK_AW'(1)
                                                            : row_base;
                end
                else
                begin
                    out_col_next = out_col_reg + CNT_W'(1);
                    base_next    = cur_base;
                    unique case (eff_mode)
                        MODE_HFLIP:     addr_next = cur_addr - BANK_AW'(1);
                        MODE_TRANSPOSE: addr_next = cur_addr + w_ext;
                        default:        addr_next = cur_addr + BANK_AW'(1);
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_cfg_reg <= MODE_VFLIP;
            w_cfg_reg    <= DIM_W'(MAX_WIDTH);
            h_cfg_reg    <= DIM_W'(MAX_HEIGHT);
            cur_mode_reg <= MODE_VFLIP;
            cur_w_reg    <= DIM_W'(MAX_WIDTH);
            cur_h_reg    <= DIM_W'(MAX_HEIGHT);
            wbank_reg    <= 1'b0;
            done_reg     <= 1'b0;
            prior_reg    <= 1'b0;
            wpos_reg     <= '0;
            base_reg     <= '0;
            addr_reg     <= '0;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MODE:
                    begin
                        unique case (cfg_data[MODE_W-1:0])
                            MODE_HFLIP:     mode_cfg_reg <= MODE_HFLIP;
                            MODE_TRANSPOSE: mode_cfg_reg <= MODE_TRANSPOSE;
                            default:        mode_cfg_reg <= MODE_VFLIP;
                        endcase
                    end
                    CFG_WIDTH:  w_cfg_reg <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
                    CFG_HEIGHT: h_cfg_reg <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
                    default:    ;
                endcase
            end
            if (acc)
            begin
                cur_mode_reg <= eff_mode;
                cur_w_reg    <= eff_w;
                cur_h_reg    <= eff_h;
            end
            wbank_reg   <= wbank_next;
            done_reg    <= done_next;
            prior_reg   <= prior_next;
            wpos_reg    <= wpos_next;
            base_reg    <= base_next;
            addr_reg    <= addr_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
        end
    end

    // write and read always hit opposite banks, so no forwarding is needed
    assign ram_req.we    = acc;
    assign ram_req.waddr = {wbank_reg, wpos_reg};
    assign ram_req.wdata = pixel;
    assign ram_req.re    = acc;
    assign ram_req.raddr = {~wbank_reg, cur_addr};

    assign meta.prior_ok  = prior_next;
    assign meta.frame_end = last_in;

endmodule

// File: rtl/ffxp_out.sv
// Read-data stage and output register with backpressure.
// Depends on ffxp_pkg and ffxp_out_if.
module ffxp_out (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       acc,
    input  ffxp_pkg::meta_t            meta,
    input  logic [ffxp_pkg::PIX_W-1:0] rdata,
    output logic                       s_ready,
    ffxp_out_if.source                 dst
);
    import ffxp_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    meta_t            s1_meta_reg;
    logic             o_valid_reg, o_valid_next;
    logic [PIX_W-1:0] o_pix_reg;
    logic             o_ok_reg, o_end_reg;
    logic             s1_move;

    // RAM read data holds while no new request is issued
    assign s1_move = s1_valid_reg && (!o_valid_reg || dst.ready);
    assign s_ready = !s1_valid_reg || s1_move;

    assign s1_valid_next = acc || (s1_valid_reg && !s1_move);
    assign o_valid_next  = s1_move || (o_valid_reg && !dst.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_meta_reg <= meta;
        end
        if (s1_move)
        begin
            o_pix_reg <= s1_meta_reg.prior_ok ? rdata : '0;
            o_ok_reg  <= s1_meta_reg.prior_ok;
            o_end_reg <= s1_meta_reg.frame_end;
        end
    end

    assign dst.valid     = o_valid_reg;
    assign dst.pixel_out = o_pix_reg;
    assign dst.out_valid = o_ok_reg;
    assign dst.frame_end = o_end_reg;

endmodule

// File: rtl/ffxp_checker.sv
// Port-level checks for the frame reorientation block, bound to the top level.
// Depends on frame_flip_transpose_macros.svh and frame_flip_transpose.
`include "frame_flip_transpose_macros.svh"

module ffxp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_vld,
    input logic        out_ready,
    input logic        out_ok,
    input logic [31:0] pixel_out
);

    `FFXP_ASSERT_NXT(a_out_hold, out_vld && !out_ready, out_vld, "output request dropped while stalled")
    `FFXP_ASSERT_IMP(a_invalid_zero, out_vld && !out_ok, pixel_out == '0, "invalid frame pixel not zero")
    `FFXP_ASSERT_NXT2(a_latency, in_valid && in_ready, out_vld, "no output two cycles after input")
    `FFXP_ASSERT_IMP(a_stall_cause, !in_ready, out_vld && !out_ready, "input stalled without output stall")

endmodule

bind frame_flip_transpose ffxp_checker u_ffxp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_vld   (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_ok    (out_ch.out_valid),
    .pixel_out (out_ch.pixel_out)
);

// File: dv/reorient_checker.sv
// Checker for the frame reorientation block: tracks the pixel stream and the
// register writes, predicts each output request, and compares it field by field.
// Depends on ffxp_pkg and the ffxp_in_if / ffxp_out_if interfaces.
module reorient_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    ffxp_in_if                               pix_in,
    ffxp_out_if                              pix_out,
    input  logic                             cfg_we,
    input  logic [ffxp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffxp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               outstanding
);
    import ffxp_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             prior_ok;
        logic             last;
    } orient_result_t;

    orient_result_t expected_q[$];

    bit [PIX_W-1:0] frame_mem [0:RAM_DEPTH-1];

    logic [MODE_W-1:0] mode_reg;
    dim_t              width_reg;
    dim_t              height_reg;

    int unsigned wr_bank;
    int unsigned wr_pos;
    int unsigned row_cnt;
    int unsigned col_cnt;
    int unsigned row_addr;
    int unsigned frame_pixels;
    int unsigned lat_w;
    int unsigned lat_h;
    orient_t     lat_mode;
    bit          prior_ok;
    bit          seen_frame;

    function automatic void clear_model();
        expected_q.delete();
        mode_reg     = MODE_VFLIP;
        width_reg    = dim_t'(MAX_WIDTH);
        height_reg   = dim_t'(MAX_HEIGHT);
        wr_bank      = 0;
        wr_pos       = 0;
        row_cnt      = 0;
        col_cnt      = 0;
        row_addr     = 0;
        frame_pixels = BANK_WORDS;
        lat_w        = MAX_WIDTH;
        lat_h        = MAX_HEIGHT;
        lat_mode     = MODE_VFLIP;
        prior_ok     = 1'b0;
        seen_frame   = 1'b0;
        mismatches   = 0;
        outstanding  = 0;
    endfunction

    function automatic int unsigned fit_dim(input dim_t v, input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    function automatic int unsigned base_of_row(input int unsigned row);
        case (lat_mode)
            MODE_TRANSPOSE: return row;
            MODE_HFLIP:     return row * lat_w;
            default:        return (lat_h - 1 - row) * lat_w;
        endcase
    endfunction

    function automatic orient_result_t reorient_pixel(input logic [PIX_W-1:0] pix);
        orient_result_t res;
        int unsigned    w;
        int unsigned    h;
        int unsigned    addr;
        int unsigned    cols;
        res = '0;
        if (wr_pos == 0)
        begin
            w = fit_dim(width_reg, MAX_WIDTH);
            h = fit_dim(height_reg, MAX_HEIGHT);
            prior_ok = seen_frame && (w == lat_w) && (h == lat_h);
            lat_w = w;
            lat_h = h;
            lat_mode = (mode_reg == MODE_HFLIP || mode_reg == MODE_TRANSPOSE) ?
                       orient_t'(mode_reg) : MODE_VFLIP;
            frame_pixels = w * h;
            row_cnt = 0;
            col_cnt = 0;
            row_addr = base_of_row(0);
        end
        if (prior_ok)
        begin
            case (lat_mode)
                MODE_TRANSPOSE: addr = row_addr + col_cnt * lat_w;
                MODE_HFLIP:     addr = row_addr + (lat_w - 1 - col_cnt);
                default:        addr = row_addr + col_cnt;
            endcase
            if (addr >= BANK_WORDS)
                addr = BANK_WORDS - 1;
            res.pixel = frame_mem[(wr_bank ^ 1) * BANK_WORDS + addr];
        end
        if (wr_pos < BANK_WORDS)
            frame_mem[wr_bank * BANK_WORDS + wr_pos] = pix;
        res.prior_ok = prior_ok;
        res.last = (wr_pos + 1 >= frame_pixels);
        if (res.last)
        begin
            wr_pos = 0;
            wr_bank ^= 1;
            seen_frame = 1'b1;
            row_cnt = 0;
            col_cnt = 0;
        end
        else
        begin
            wr_pos++;
            col_cnt++;
            cols = (lat_mode == MODE_TRANSPOSE) ? lat_h : lat_w;
            if (col_cnt >= cols)
            begin
                col_cnt = 0;
                row_cnt++;
                row_addr = base_of_row(row_cnt);
            end
        end
        return res;
    endfunction

    initial
    begin
        clear_model();
    end

    always @(posedge clk or negedge rst_n)
    begin
        orient_result_t want;
        if (!rst_n)
        begin
            clear_model();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:   mode_reg = cfg_data[MODE_W-1:0];
                    CFG_WIDTH:  width_reg = cfg_data;
                    CFG_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    $error("output request with no pixel pending");
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (pix_out.pixel_out !== want.pixel)
                    begin
                        mismatches++;
                        $error("pixel_out: expected %h, got %h", want.pixel, pix_out.pixel_out);
                    end
                    if (pix_out.out_valid !== want.prior_ok)
                    begin
                        mismatches++;
                        $error("out_valid: expected %b, got %b", want.prior_ok,
                               pix_out.out_valid);
                    end
                    if (pix_out.frame_end !== want.last)
                    begin
                        mismatches++;
                        $error("frame_end: expected %b, got %b", want.last, pix_out.frame_end);
                    end
                end
            end
            if (pix_in.valid === 1'b1 && pix_in.ready === 1'b1)
                expected_q.push_back(reorient_pixel(pix_in.pixel_in));
        end
        outstanding = expected_q.size();
    end

endmodule

// File: dv/tb_frame_flip_transpose.sv
// Testbench top for frame_flip_transpose: clock, reset, register writes and
// pixel stimulus with random flow control; verdict from reorient_checker.
// Depends on ffxp_pkg, ffxp_if, the block's RTL and reorient_checker.
module tb_frame_flip_transpose;
    import ffxp_pkg::*;

    localparam int RUN_ITEMS   = 1700;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD   = 64;

    // register index past the defined set, and the undefined mode code
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int cycles;
    int sent;
    bit hold_req;
    bit tx_steady;

    ffxp_in_if  in_ch ();
    ffxp_out_if out_ch ();

    frame_flip_transpose dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    reorient_checker orient_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_in      (in_ch),
        .pix_out     (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // output side: random back-pressure, free-running stretches, long hold on request
    initial
    begin
        int pick;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                out_ch.ready <= (pick < 70);
                if (pick < 4)
                begin
                    repeat ($urandom_range(20, 60))
                    begin
                        @(negedge clk);
                        if (hold_req)
                            break;
                    end
                end
                else if (pick < 70)
                    @(negedge clk);
                else
                begin
                    repeat ((pick < 96) ? $urandom_range(1, 3) : $urandom_range(8, 30))
                    begin
                        @(negedge clk);
                        if (hold_req)
                            break;
                    end
                end
            end
        end
    end

    task automatic push_pixel(input logic [PIX_W-1:0] pix);
        int pick;
        in_ch.valid <= 1'b1;
        in_ch.pixel_in <= pix;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sent++;
        @(negedge clk);
        if (!tx_steady)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 65)
            begin
                in_ch.valid <= 1'b0;
                repeat ((pick < 95) ? $urandom_range(1, 3) : $urandom_range(8, 25))
                    @(negedge clk);
            end
        end
    endtask

    task automatic send_run(input int count);
        logic [PIX_W-1:0] pix;
        repeat (count)
        begin
            case ($urandom_range(0, 15))
                0:       pix = '0;
                1:       pix = '1;
                default: pix = $urandom;
            endcase
            push_pixel(pix);
        end
    endtask

    // wait until every predicted pixel has come out, plus pipeline drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input dim_t w, input dim_t h);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SPARE;
        cfg_data <= CFG_DATA_W'($urandom_range(0, 511));
        @(negedge clk);
        cfg_index <= CFG_MODE;
        cfg_data <= CFG_DATA_W'(mode);
        @(negedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int                phase_no;
        int                area;
        int                count;
        int                weff;
        int                heff;
        dim_t              wraw;
        dim_t              hraw;
        logic [MODE_W-1:0] mode;

        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.pixel_in = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        sent = 0;
        hold_req = 1'b0;
        tx_steady = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // first frame invalid, then vertical flip of it with all-zero/all-one pixels
        configure(MODE_VFLIP, 9'd3, 9'd2);
        push_pixel('0);
        push_pixel('1);
        send_run(10);
        settle();
        // same geometry, new mode: still valid
        configure(MODE_TRANSPOSE, 9'd3, 9'd2);
        send_run(6);
        settle();
        // undefined mode acts as vertical flip; zero width counts as one
        configure(MODE_SPARE, 9'd0, 9'd2);
        send_run(5);
        settle();
        // write while a frame is half done: applies from the next frame
        configure(MODE_HFLIP, 9'd2, 9'd1);
        send_run(5);
        weff = 2;
        heff = 1;

        phase_no = 0;
        while (sent < RUN_ITEMS)
        begin
            settle();
            tx_steady = ($urandom_range(0, 3) == 0);
            mode = MODE_W'($urandom_range(0, 3));
            if (phase_no % 20 == 1)
            begin
                if ((phase_no / 20) % 2 == 0)
                begin
                    weff = MAX_WIDTH;
                    heff = $urandom_range(1, 2);
                end
                else
                begin
                    weff = $urandom_range(1, 2);
                    heff = MAX_HEIGHT;
                end
            end
            else if (phase_no != 0 && $urandom_range(0, 1) == 0)
            begin
                // keep geometry so the next frame is valid
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                weff = $urandom_range(1, 16);
                heff = $urandom_range(1, 16);
            end
            else
            begin
                weff = $urandom_range(1, 5);
                heff = $urandom_range(1, 5);
            end
            wraw = dim_t'(weff);
            hraw = dim_t'(heff);
            if (weff == 1 && $urandom_range(0, 1) == 0)
                wraw = '0;
            if (heff == 1 && $urandom_range(0, 1) == 0)
                hraw = '0;
            if (weff == MAX_WIDTH && $urandom_range(0, 1) == 0)
                wraw = dim_t'($urandom_range(MAX_WIDTH + 1, 511));
            if (heff == MAX_HEIGHT && $urandom_range(0, 1) == 0)
                hraw = dim_t'($urandom_range(MAX_HEIGHT + 1, 511));
            configure(mode, wraw, hraw);

            area = weff * heff;
            if (area > 64)
                count = 2 * area + $urandom_range(0, area / 4);
            else
                count = area * $urandom_range(1, 3) + $urandom_range(0, area - 1);
            if (phase_no == 0 || $urandom_range(0, 7) == 0)
            begin
                // long output hold while input keeps coming
                hold_req = 1'b1;
                tx_steady = 1'b1;
                count = count + 40;
            end
            // keep the total close to the planned number of pixels
            if (count > RUN_ITEMS + 40 - sent)
                count = RUN_ITEMS + 40 - sent;
            send_run(count);
            phase_no++;
        end

        settle();
        repeat (4) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
